FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level unit.
// The clock and reset are taken from the enclosing module, named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWHC_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("swhc same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWHC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("swhc next-cycle check failed");

`endif

FILE: rtl/swhc_pkg.sv
`default_nettype none
package swhc_pkg;

   localparam int WINDOW_MAX_DEFAULT = 256;

   localparam int POS_W      = 32;
   localparam int READS_W    = 16;
   localparam int CFG_W      = 9;
   localparam int HIT_W      = 9;
   localparam int DATA_W     = 32;
   localparam int REG_ADDR_W = 3;

   localparam logic [CFG_W-1:0] SPAN_RESET = 9'd16;
   localparam logic [HIT_W-1:0] HIT_MAX    = 9'd511;

   typedef enum logic [0:0] {
      REG_SPAN = 1'b0
   } swhc_reg_type;

   // Per-word information handed from the addressing stage to the tally stage.
   typedef struct packed {
      logic             strand;
      logic             full;
      logic             mark;
      logic             hit_oldest;
      logic             hit_middle;
      logic [POS_W-1:0] pos;
   } swhc_slot_type;

endpackage
`default_nettype wire

FILE: rtl/swhc_ram.sv
`default_nettype none
module swhc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/swhc_ring_ctl.sv
`default_nettype none
module swhc_ring_ctl #(
   parameter int WINDOW_MAX = swhc_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]   win,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]   clear_win,
   input  wire logic                              clear,
   input  wire logic                              accept,
   input  wire logic                              strand,
   input  wire logic [swhc_pkg::POS_W-1:0]        pos,
   input  wire logic                              mark,
   output logic      [$clog2(WINDOW_MAX)+1-1:0]   wr_addr,
   output logic      [$clog2(WINDOW_MAX)+1-1:0]   oldest_addr,
   output logic      [$clog2(WINDOW_MAX)+1-1:0]   middle_addr,
   output swhc_pkg::swhc_slot_type                slot
);

   import swhc_pkg::*;

   localparam int W_W   = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int RESET_WIN = (int'(SPAN_RESET) > WINDOW_MAX) ?
                              WINDOW_MAX : int'(SPAN_RESET);

   logic [IDX_W-1:0] head_ff [2];
   logic [IDX_W-1:0] head_in [2];
   logic [W_W-1:0]   fill_ff [2];
   logic [W_W-1:0]   fill_in [2];

   logic [IDX_W-1:0] head_new;
   logic [IDX_W-1:0] oldest;
   logic [IDX_W-1:0] middle;
   logic [W_W-1:0]   head_inc;
   logic [W_W-1:0]   oldest_inc;
   logic [W_W:0]     middle_sum;
   logic [W_W-1:0]   fill_new;

   always_comb begin
      head_inc = W_W'(head_ff[strand]) + W_W'(1);
      head_new = (head_inc >= win) ? '0 : head_inc[IDX_W-1:0];

      oldest_inc = W_W'(head_new) + W_W'(1);
      oldest     = (oldest_inc >= win) ? '0 : oldest_inc[IDX_W-1:0];

      middle_sum = (W_W+1)'(oldest) + (W_W+1)'(win >> 1);
      if (middle_sum >= (W_W+1)'(win)) begin
         middle_sum = middle_sum - (W_W+1)'(win);
      end
      middle = middle_sum[IDX_W-1:0];

      fill_new = (fill_ff[strand] < win) ? fill_ff[strand] + W_W'(1) : fill_ff[strand];

      head_in = head_ff;
      fill_in = fill_ff;
      if (clear) begin
         for (int s = 0; s < 2; s++) begin
            head_in[s] = IDX_W'(clear_win - W_W'(1));
            fill_in[s] = '0;
         end
      end else if (accept) begin
         head_in[strand] = head_new;
         fill_in[strand] = fill_new;
      end

      wr_addr     = {strand, head_new};
      oldest_addr = {strand, oldest};
      middle_addr = {strand, middle};

      slot.strand     = strand;
      slot.full       = (fill_new >= win);
      slot.mark       = mark;
      slot.hit_oldest = (oldest == head_new);
      slot.hit_middle = (middle == head_new);
      slot.pos        = pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            head_ff[s] <= IDX_W'(RESET_WIN - 1);
            fill_ff[s] <= '0;
         end
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/swhc_tally.sv
`default_nettype none
module swhc_tally #(
   parameter int WINDOW_MAX = swhc_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic                         advance,
   input  wire swhc_pkg::swhc_slot_type      slot,
   input  wire logic                         oldest_mark_mem,
   input  wire logic                         middle_mark_mem,
   output logic                              emit,
   output logic      [swhc_pkg::HIT_W-1:0]   hits
);

   import swhc_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int EXT_W = (CNT_W > HIT_W) ? CNT_W : HIT_W;

   logic [CNT_W-1:0] total_ff [2];
   logic [CNT_W-1:0] total_in [2];

   logic             oldest_mark;
   logic             middle_mark;
   logic [CNT_W-1:0] total_new;
   logic [EXT_W-1:0] total_ext;

   always_comb begin
      oldest_mark = slot.hit_oldest ? slot.mark : oldest_mark_mem;
      middle_mark = slot.hit_middle ? slot.mark : middle_mark_mem;
      total_new   = total_ff[slot.strand] + CNT_W'(slot.mark);
      emit        = slot.full && middle_mark && (total_new > CNT_W'(1));

      total_ext = EXT_W'(total_new);
      hits = (total_ext > EXT_W'(HIT_MAX)) ? HIT_MAX : total_ext[HIT_W-1:0];

      total_in = total_ff;
      if (clear) begin
         total_in[0] = '0;
         total_in[1] = '0;
      end else if (advance) begin
         total_in[slot.strand] = slot.full ? total_new - CNT_W'(oldest_mark) : total_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff[0] <= '0;
         total_ff[1] <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/strand_window_hit_cluster_unit.sv
`default_nettype none
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  strand, position, mutation read count
// rsp       out        rsp_valid/rsp_stall  strand, region start/end, hit count
// csr       in/out     psel/penable/pready  window span register at byte address 0
//
// One site is accepted per cycle unless req_stall holds it; a region passes through the slot and response registers.
// Both ring memories are read and written in the accept cycle, with the read data
// registered, and the per-strand mark count is updated when the slot stage moves on.
// Reset is synchronous; the ring memories are not cleared, only their pointers.
// A stalled region holds; input stalls only when a second region waits behind it.
`include "assert_macros.svh"
module strand_window_hit_cluster_unit #(
   parameter int WINDOW_MAX = swhc_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_strand_plus,
   input  wire logic [swhc_pkg::POS_W-1:0]          req_position,
   input  wire logic [swhc_pkg::READS_W-1:0]        req_mutation_reads,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_strand_plus_res,
   output logic      [swhc_pkg::POS_W-1:0]          rsp_region_start,
   output logic      [swhc_pkg::POS_W-1:0]          rsp_region_end,
   output logic      [swhc_pkg::HIT_W-1:0]          rsp_hit_count,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [swhc_pkg::REG_ADDR_W-1:0]     paddr,
   input  wire logic [swhc_pkg::DATA_W-1:0]         pwdata,
   output logic      [swhc_pkg::DATA_W-1:0]         prdata,
   output logic                                     pready
);

   import swhc_pkg::*;

   localparam int W_W    = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W  = $clog2(WINDOW_MAX);
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int EXT_W  = (W_W > CFG_W) ? W_W : CFG_W;

   function automatic logic [W_W-1:0] clamp_window(input logic [CFG_W-1:0] ws);
      logic [EXT_W-1:0] e;
      e = EXT_W'(ws);
      if (e == '0) begin
         e = EXT_W'(1);
      end
      if (e > EXT_W'(WINDOW_MAX)) begin
         e = EXT_W'(WINDOW_MAX);
      end
      return e[W_W-1:0];
   endfunction

   logic [CFG_W-1:0] ws_ff;
   logic [W_W-1:0]   w_ff;
   logic             cfg_write;
   logic [W_W-1:0]   clear_win;
   swhc_reg_type     reg_sel;

   logic               accept;
   logic               req_mark;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  oldest_addr;
   logic [ADDR_W-1:0]  middle_addr;
   swhc_slot_type      slot;

   logic               s1_v_ff;
   logic               s1_v_in;
   swhc_slot_type      s1_ff;
   logic               s1_move;
   logic               s1_emit;
   logic [HIT_W-1:0]   s1_hits;
   logic [POS_W:0]     oldest_word;
   logic               middle_mark_mem;
   logic [POS_W-1:0]   oldest_pos;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_load;
   logic               rsp_strand_ff;
   logic [POS_W-1:0]   rsp_start_ff;
   logic [POS_W-1:0]   rsp_end_ff;
   logic [HIT_W-1:0]   rsp_hits_ff;

   assign reg_sel   = swhc_reg_type'(paddr[REG_ADDR_W-1:2]);
   assign cfg_write = psel && penable && pwrite && (reg_sel == REG_SPAN);
   assign clear_win = clamp_window(pwdata[CFG_W-1:0]);
   assign pready    = 1'b1;

   always_comb begin
      unique case (reg_sel)
         REG_SPAN: prdata = DATA_W'(ws_ff);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= SPAN_RESET;
         w_ff  <= clamp_window(SPAN_RESET);
      end else if (cfg_write) begin
         ws_ff <= pwdata[CFG_W-1:0];
         w_ff  <= clear_win;
      end
   end

   assign req_mark  = (req_mutation_reads != '0);
   assign s1_move   = s1_v_ff && (!s1_emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_v_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   swhc_ring_ctl #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_ring_ctl (
      .clock       (clock),
      .reset       (reset),
      .win         (w_ff),
      .clear_win   (clear_win),
      .clear       (cfg_write),
      .accept      (accept),
      .strand      (req_strand_plus),
      .pos         (req_position),
      .mark        (req_mark),
      .wr_addr     (wr_addr),
      .oldest_addr (oldest_addr),
      .middle_addr (middle_addr),
      .slot        (slot)
   );

   swhc_ram #(
      .WIDTH (POS_W + 1),
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data ({req_mark, req_position}),
      .rd_en   (accept),
      .rd_addr (oldest_addr),
      .rd_data (oldest_word)
   );

   swhc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_mark),
      .rd_en   (accept),
      .rd_addr (middle_addr),
      .rd_data (middle_mark_mem)
   );

   assign s1_v_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= slot;
      end
   end

   swhc_tally #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_tally (
      .clock           (clock),
      .reset           (reset),
      .clear           (cfg_write),
      .advance         (s1_move),
      .slot            (s1_ff),
      .oldest_mark_mem (oldest_word[POS_W]),
      .middle_mark_mem (middle_mark_mem),
      .emit            (s1_emit),
      .hits            (s1_hits)
   );

   assign oldest_pos   = s1_ff.hit_oldest ? s1_ff.pos : oldest_word[POS_W-1:0];
   assign rsp_load     = s1_move && s1_emit;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_strand_ff <= s1_ff.strand;
         rsp_start_ff  <= oldest_pos - POS_W'(1);
         rsp_end_ff    <= s1_ff.pos;
         rsp_hits_ff   <= s1_hits;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_strand_plus_res = rsp_strand_ff;
   assign rsp_region_start    = rsp_start_ff;
   assign rsp_region_end      = rsp_end_ff;
   assign rsp_hit_count       = rsp_hits_ff;

   `SWHC_ASSERT_IMPL(a_hits_min, rsp_valid_ff, rsp_hits_ff >= HIT_W'(2))
   `SWHC_ASSERT_IMPL(a_backpressure, s1_v_ff && s1_emit && rsp_valid_ff && rsp_stall, req_stall)
   `SWHC_ASSERT_NEXT(a_region_end, rsp_load, rsp_valid_ff && (rsp_end_ff == $past(s1_ff.pos)))

endmodule
`default_nettype wire

FILE: dv/strand_window_hit_cluster_unit_test.sv
`timescale 1ns / 100ps

module strand_window_hit_cluster_unit_test;
   import swhc_pkg::*;

   localparam int unsigned RING_DEPTH = WINDOW_MAX_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned PHASES = 10;

   typedef struct packed {
      logic             strand;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic [HIT_W-1:0] hits;
   } region_word_type;

   class strand_window_tracker;
      logic [POS_W-1:0] pos_ring [2][RING_DEPTH];
      bit               mark_ring [2][RING_DEPTH];
      int unsigned      span;
      int unsigned      head [2];
      int unsigned      tail [2];
      int unsigned      fill [2];
      int unsigned      marks [2];
      region_word_type  pending_regions [$];
      int unsigned      failures;

      function new();
         failures = 0;
         set_window(32'(SPAN_RESET));
      endfunction

      // A write to the window size restarts both strands.
      function void set_window(logic [DATA_W-1:0] value);
         span = 32'(value[CFG_W-1:0]);
         if (span < 1) span = 1;
         if (span > RING_DEPTH) span = RING_DEPTH;
         for (int s = 0; s < 2; s++) begin
            head[s] = span - 1;
            tail[s] = span - 1;
            fill[s] = 0;
            marks[s] = 0;
         end
      endfunction

      function void note_site(logic strand, logic [POS_W-1:0] pos,
                              logic [READS_W-1:0] reads);
         int unsigned     s, h, t, mid;
         bit              mark;
         region_word_type region;
         s = 32'(strand);
         mark = (reads != '0);
         h = (head[s] + 1) % span;
         pos_ring[s][h] = pos;
         mark_ring[s][h] = mark;
         marks[s] += 32'(mark);
         head[s] = h;
         if (fill[s] < span) fill[s]++;
         if (fill[s] >= span) begin
            tail[s] = (tail[s] + 1) % span;
            t = tail[s];
            mid = (t + span / 2) % span;
            if (mark_ring[s][mid] && marks[s] > 1) begin
               region.strand = strand;
               region.start_pos = pos_ring[s][t] - 32'd1;
               region.end_pos = pos_ring[s][h];
               region.hits = (marks[s] > HIT_MAX) ? HIT_MAX : HIT_W'(marks[s]);
               pending_regions.push_back(region);
            end
            marks[s] -= 32'(mark_ring[s][t]);
         end
      endfunction

      function void compare_field(string what, logic [POS_W-1:0] want,
                                  logic [POS_W-1:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         end
      endfunction

      function void check_region(logic strand, logic [POS_W-1:0] start_pos,
                                 logic [POS_W-1:0] end_pos, logic [HIT_W-1:0] hits);
         region_word_type want;
         if (pending_regions.size() == 0) begin
            failures++;
            $display("%0t: region word not expected, expected none, actual %0h %0h %0h %0h",
                     $time, strand, start_pos, end_pos, hits);
            return;
         end
         want = pending_regions.pop_front();
         compare_field("strand", 32'(want.strand), 32'(strand));
         compare_field("region_start", want.start_pos, start_pos);
         compare_field("region_end", want.end_pos, end_pos);
         compare_field("hit_count", 32'(want.hits), 32'(hits));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_strand_plus;
   logic [POS_W-1:0]      req_position;
   logic [READS_W-1:0]    req_mutation_reads;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_strand_plus_res;
   logic [POS_W-1:0]      rsp_region_start;
   logic [POS_W-1:0]      rsp_region_end;
   logic [HIT_W-1:0]      rsp_hit_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [REG_ADDR_W-1:0] paddr;
   logic [DATA_W-1:0]     pwdata;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;

   strand_window_tracker board = new();
   bit steady = 1'b0;
   bit hold_request = 1'b0;

   strand_window_hit_cluster_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_strand_plus     (req_strand_plus),
      .req_position        (req_position),
      .req_mutation_reads  (req_mutation_reads),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_strand_plus_res (rsp_strand_plus_res),
      .rsp_region_start    (rsp_region_start),
      .rsp_region_end      (rsp_region_end),
      .rsp_hit_count       (rsp_hit_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Each accepted region word is followed by a random stall unless steady is set; a requested hold
   // keeps the channel stalled long enough for the block to back up.
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_region(rsp_strand_plus_res, rsp_region_start, rsp_region_end,
                               rsp_hit_count);
            stall_left = steady ? 0 : $urandom_range(9);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_site(logic strand, logic [POS_W-1:0] pos, logic [READS_W-1:0] reads);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_strand_plus <= strand;
      req_position <= pos;
      req_mutation_reads <= reads;
      do @(posedge clock); while (req_stall);
      board.note_site(strand, pos, reads);
   endtask

   task automatic write_window(logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_SPAN, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      board.set_window(value);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_regions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int unsigned        plan [PHASES];
      int unsigned        span;
      int unsigned        count;
      int unsigned        mark_odds;
      logic [POS_W-1:0]   next_pos [2];
      logic [READS_W-1:0] reads;
      logic [DATA_W-1:0]  value;
      logic               strand;
      bit                 wide;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_strand_plus <= 1'b0;
      req_position <= '0;
      req_mutation_reads <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset window of 16: the first full window on the plus strand starts at
      // position 1, and the next one ends at the highest position.
      for (int i = 0; i < 17; i++) begin
         case (i)
            0: reads = 16'h0001;
            8: reads = 16'hFFFF;
            9: reads = 16'h8000;
            16: reads = 16'h00FF;
            default: reads = '0;
         endcase
         send_site(1'b1, (i == 16) ? 32'hFFFF_FFFF : 32'(i + 1), reads);
      end
      for (int i = 0; i < 6; i++) send_site(1'b0, 32'(1000 + i), 16'(i * 3));

      // Zero acts as one, and anything above the ring depth acts as the depth.
      plan = '{2, 0, 1, 3, 6, 5, 511, 8, 4, 0};
      plan[PHASES-1] = $urandom_range(40, 2);
      for (int p = 0; p < PHASES; p++) begin
         settle();
         span = plan[p];
         value = $urandom();
         value[CFG_W-1:0] = span[CFG_W-1:0];
         write_window(value);
         steady = (p == 0) || ($urandom_range(3) == 0);
         wide = (span >= RING_DEPTH);
         count = wide ? 290 : 45;
         mark_odds = $urandom_range(3, 1);
         next_pos[0] = $urandom_range(32'hFFFF_FFFF, 1);
         next_pos[1] = (p == 3) ? 32'hFFFF_FFE0 : $urandom_range(32'hFFFF_FFFF, 1);
         if (p == 0) hold_request = 1'b1;
         for (int i = 0; i < count; i++) begin
            strand = wide ? ($urandom_range(15) != 0) : 1'($urandom_range(1));
            if ($urandom_range(15) == 0) next_pos[strand] = $urandom_range(32'hFFFF_FFFF, 1);
            if ($urandom_range(3) < mark_odds) begin
               reads = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(65535, 1));
            end else begin
               reads = '0;
            end
            send_site(strand, next_pos[strand], reads);
            next_pos[strand] = next_pos[strand] + 32'd1;
            if (next_pos[strand] == '0) next_pos[strand] = 32'd1;
         end
      end
      settle();
      repeat (20) @(posedge clock);

      if (board.failures == 0 && board.pending_regions.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl
rtl/swhc_pkg.sv
rtl/swhc_ram.sv
rtl/swhc_ring_ctl.sv
rtl/swhc_tally.sv
rtl/strand_window_hit_cluster_unit.sv
dv/strand_window_hit_cluster_unit_test.sv
